>>> design/calendar_age_and_weekday_unit_assert.svh
// Assertion macros for the calendar age and weekday unit.
// Both macros sample on the rising edge of clk; the first one is quiet
// while rst_n is low, the second one checks through reset as well.
`ifndef CALENDAR_AGE_AND_WEEKDAY_UNIT_ASSERT_SVH
`define CALENDAR_AGE_AND_WEEKDAY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CAW_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("caw assertion failed");
`define CAW_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("caw assertion failed");
`else
`define CAW_ASSERT(label, prop)
`define CAW_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> design/caw_pkg.sv
package caw_pkg;

    // Field widths
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int SERIAL_W  = 22;
    localparam int WEEKS_W   = 19;
    localparam int HOURS_W   = 27;
    localparam int MINUTES_W = 33;
    localparam int WDAY_W    = 3;

    // Pipeline depth: four stages per date front end, seven in all
    localparam int FRONT_STAGES = 4;
    localparam int PIPE_STAGES  = 7;

    // Calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;

    // Constant division helpers
    // floor(p / 100) = (p * 5243) >> 19 for p below 43690
    localparam logic [12:0] RECIP100       = 13'd5243;
    localparam int          RECIP100_SHIFT = 19;
    // 7209 is the inverse of 25 modulo 2**14: y divides by 25 exactly
    // when the truncated product is at most floor((2**14 - 1) / 25)
    localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;
    // floor(x / 7) = (x * 4793491) >> 25 for x below 2**22
    localparam logic [22:0] RECIP7       = 23'd4793491;
    localparam int          RECIP7_SHIFT = 25;

    typedef struct packed {
        logic [YEAR_W-1:0]  birth_year;
        logic [MONTH_W-1:0] birth_month;
        logic [DAY_W-1:0]   birth_day;
        logic [YEAR_W-1:0]  now_year;
        logic [MONTH_W-1:0] now_month;
        logic [DAY_W-1:0]   now_day;
    } caw_item_t;

    typedef struct packed {
        logic                 date_error;
        logic [YEAR_W-1:0]    age_years;
        logic [MONTH_W-1:0]   age_months;
        logic [DAY_W-1:0]     age_days;
        logic [SERIAL_W-1:0]  total_days;
        logic [WEEKS_W-1:0]   total_weeks;
        logic [HOURS_W-1:0]   total_hours;
        logic [MINUTES_W-1:0] total_minutes;
        logic [WDAY_W-1:0]    birth_weekday;
        logic [WDAY_W-1:0]    now_weekday;
    } caw_result_t;

    // Clamped date with the leap flag of its year
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               leap;
    } caw_date_t;

    // Length of a month
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Days before the first of a month in a common year
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] month);
        logic [8:0] start;
        case (month)
            4'd2:    start = 9'd31;
            4'd3:    start = 9'd59;
            4'd4:    start = 9'd90;
            4'd5:    start = 9'd120;
            4'd6:    start = 9'd151;
            4'd7:    start = 9'd181;
            4'd8:    start = 9'd212;
            4'd9:    start = 9'd243;
            4'd10:   start = 9'd273;
            4'd11:   start = 9'd304;
            4'd12:   start = 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

>>> design/caw_date_front.sv
module caw_date_front
    import caw_pkg::*;
(
    input  logic                    clk,
    input  logic [FRONT_STAGES-1:0] load,
    input  logic [YEAR_W-1:0]       year,
    input  logic [MONTH_W-1:0]      month,
    input  logic [DAY_W-1:0]        day,
    output caw_date_t               date,
    output logic [SERIAL_W-1:0]     serial
);

    // Stage 1 signals
    logic [YEAR_W-1:0]   s1_year_next,  s1_year_reg;
    logic [MONTH_W-1:0]  s1_month_next, s1_month_reg;
    logic [DAY_W-1:0]    s1_day_next,   s1_day_reg;
    // Stage 2 signals
    logic [YEAR_W-1:0]   prev_year;
    logic [26:0]         prod100;
    logic [27:0]         prod_inv25;
    logic                div25;
    logic [YEAR_W-1:0]   s2_year_reg;
    logic [MONTH_W-1:0]  s2_month_reg;
    logic [DAY_W-1:0]    s2_day_reg;
    logic                s2_leap_next,  s2_leap_reg;
    logic [SERIAL_W-1:0] s2_p365_next,  s2_p365_reg;
    logic [11:0]         s2_p4_reg;
    logic [6:0]          s2_q100_next,  s2_q100_reg;
    // Stage 3 signals
    logic [DAY_W-1:0]    month_len;
    caw_date_t           s3_date_next,  s3_date_reg;
    logic [SERIAL_W-1:0] s3_ybase_next, s3_ybase_reg;
    // Stage 4 signals
    logic [SERIAL_W-1:0] s4_serial_next, s4_serial_reg;

    // Clamp year and month into range
    always_comb
    begin
        if (year < YEAR_MIN)
            s1_year_next = YEAR_MIN;
        else if (year > YEAR_MAX)
            s1_year_next = YEAR_MAX;
        else
            s1_year_next = year;
        if (month < MONTH_JAN)
            s1_month_next = MONTH_JAN;
        else if (month > MONTH_MAX)
            s1_month_next = MONTH_MAX;
        else
            s1_month_next = month;
        s1_day_next = day;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_year_reg  <= s1_year_next;
            s1_month_reg <= s1_month_next;
            s1_day_reg   <= s1_day_next;
        end
    end

    // Leap flag and the quotients of the elapsed years
    always_comb
    begin
        prev_year    = s1_year_reg - 14'd1;
        prod100      = 27'(prev_year) * 27'(RECIP100);
        s2_q100_next = prod100[RECIP100_SHIFT +: 7];
        s2_p365_next = 22'(prev_year) * 22'(DAYS_PER_YEAR);
        prod_inv25   = 28'(s1_year_reg) * 28'(INV25);
        div25        = (prod_inv25[YEAR_W-1:0] <= DIV25_LIMIT);
        s2_leap_next = (s1_year_reg[1:0] == 2'd0) && (!div25 || s1_year_reg[3:0] == 4'd0);
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_year_reg  <= s1_year_reg;
            s2_month_reg <= s1_month_reg;
            s2_day_reg   <= s1_day_reg;
            s2_leap_reg  <= s2_leap_next;
            s2_p365_reg  <= s2_p365_next;
            s2_p4_reg    <= prev_year[YEAR_W-1:2];
            s2_q100_reg  <= s2_q100_next;
        end
    end

    // Clamp the day to its month and sum the day count of whole years
    always_comb
    begin
        month_len          = month_days(s2_month_reg, s2_leap_reg);
        s3_date_next.year  = s2_year_reg;
        s3_date_next.month = s2_month_reg;
        s3_date_next.leap  = s2_leap_reg;
        if (s2_day_reg < DAY_MIN)
            s3_date_next.day = DAY_MIN;
        else if (s2_day_reg > month_len)
            s3_date_next.day = month_len;
        else
            s3_date_next.day = s2_day_reg;
        s3_ybase_next = s2_p365_reg + 22'(s2_p4_reg) - 22'(s2_q100_reg)
                      + 22'(s2_q100_reg[6:2]);
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_date_reg  <= s3_date_next;
            s3_ybase_reg <= s3_ybase_next;
        end
    end

    // Add the month offset, the leap day and the day of month
    always_comb
    begin
        s4_serial_next = s3_ybase_reg + 22'(month_start(s3_date_reg.month))
                       + 22'(s3_date_reg.month > MONTH_FEB && s3_date_reg.leap)
                       + 22'(s3_date_reg.day);
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
            s4_serial_reg <= s4_serial_next;
    end

    assign date   = s3_date_reg;
    assign serial = s4_serial_reg;

endmodule

>>> design/calendar_age_and_weekday_unit.sv
// Calendar age and weekday unit.
// The item channel (item, item_valid, item_stall) carries a birth date and a
// current Gregorian date; the result channel (result, result_valid,
// result_stall) returns one result per item: an error flag when the birth
// date lies after the current date, otherwise the age in years, months and
// days, the elapsed days, whole weeks, hours and minutes, and the weekday of
// both dates (0 is Sunday). Out-of-range fields are clamped first.
// A result reaches result_valid after passing through the seven register
// stages, each of which holds one item. A new item is taken every cycle
// while item_stall is low, and a stage with a free slot fills even while
// a later one is held, so bubbles close up.
// When result_stall is high the last stage holds its result unchanged and
// item_stall rises once every stage in front of it is full.
// Reset clears all stage valid flags; the pipeline comes out of reset empty
// and ready to accept an item in the first cycle.
`include "calendar_age_and_weekday_unit_assert.svh"

module calendar_age_and_weekday_unit
    import caw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  caw_item_t   item,
    input  logic        item_valid,
    output logic        item_stall,
    output caw_result_t result,
    output logic        result_valid,
    input  logic        result_stall
);

    // Stage control
    logic [PIPE_STAGES-1:0] load;
    logic [PIPE_STAGES-1:0] vld_next, vld_reg;

    // Front end outputs
    caw_date_t           birth_date, now_date;
    logic [SERIAL_W-1:0] birth_serial, now_serial;

    // Stage 4 signals
    logic                later, day_ok, md_ok;
    logic [MONTH_W-1:0]  prev_month;
    logic [DAY_W-1:0]    prev_len, borrow_day;
    logic                s4_err_next, s4_err_reg;
    logic [YEAR_W-1:0]   s4_years_next, s4_years_reg;
    logic [MONTH_W-1:0]  s4_months_next, s4_months_reg;
    logic [DAY_W-1:0]    s4_days_next, s4_days_reg;

    // Stage 5 signals
    logic [44:0]         prod_birth7, prod_now7;
    logic                s5_err_reg;
    logic [YEAR_W-1:0]   s5_years_reg;
    logic [MONTH_W-1:0]  s5_months_reg;
    logic [DAY_W-1:0]    s5_days_reg;
    logic [SERIAL_W-1:0] s5_total_next, s5_total_reg;
    logic [WDAY_W-1:0]   s5_birth_lo_reg, s5_birth_q_next, s5_birth_q_reg;
    logic [WDAY_W-1:0]   s5_now_lo_reg, s5_now_q_next, s5_now_q_reg;

    // Stage 6 signals
    logic [44:0]         prod_total7;
    logic                s6_err_reg;
    logic [YEAR_W-1:0]   s6_years_reg;
    logic [MONTH_W-1:0]  s6_months_reg;
    logic [DAY_W-1:0]    s6_days_reg;
    logic [SERIAL_W-1:0] s6_total_reg;
    logic [WEEKS_W-1:0]  s6_weeks_next, s6_weeks_reg;
    logic [HOURS_W-1:0]  s6_hours_next, s6_hours_reg;
    logic [WDAY_W-1:0]   s6_birth_wd_next, s6_birth_wd_reg;
    logic [WDAY_W-1:0]   s6_now_wd_next, s6_now_wd_reg;

    // Stage 7 signals
    caw_result_t         result_next, result_reg;

    // Advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        load[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || !result_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
            load[k] = !vld_reg[k] || load[k+1];
        vld_next[0] = load[0] ? item_valid : vld_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++)
            vld_next[k] = load[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign item_stall   = !load[0];
    assign result_valid = vld_reg[PIPE_STAGES-1];
    assign result       = result_reg;

    // Clamp and count days for each date
    caw_date_front u_birth_front (
        .clk    (clk),
        .load   (load[FRONT_STAGES-1:0]),
        .year   (item.birth_year),
        .month  (item.birth_month),
        .day    (item.birth_day),
        .date   (birth_date),
        .serial (birth_serial)
    );

    caw_date_front u_now_front (
        .clk    (clk),
        .load   (load[FRONT_STAGES-1:0]),
        .year   (item.now_year),
        .month  (item.now_month),
        .day    (item.now_day),
        .date   (now_date),
        .serial (now_serial)
    );

    // Order the dates and work out years, months and days with borrow
    always_comb
    begin
        later  = {birth_date.year, birth_date.month, birth_date.day}
               > {now_date.year, now_date.month, now_date.day};
        day_ok = now_date.day >= birth_date.day;
        md_ok  = (now_date.month > birth_date.month)
              || (now_date.month == birth_date.month && day_ok);

        s4_err_next   = later;
        s4_years_next = now_date.year - birth_date.year - 14'(!md_ok);

        if (now_date.month >= birth_date.month)
            s4_months_next = md_ok ? now_date.month - birth_date.month : 4'd11;
        else if (day_ok)
            s4_months_next = 4'd12 + now_date.month - birth_date.month;
        else
            s4_months_next = 4'd11 + now_date.month - birth_date.month;

        // Borrow from the month before the current one, December for January
        prev_month = (now_date.month == MONTH_JAN) ? MONTH_MAX : now_date.month - 4'd1;
        prev_len   = month_days(prev_month, now_date.leap);
        borrow_day = (birth_date.day > prev_len) ? prev_len : birth_date.day;
        if (day_ok)
            s4_days_next = now_date.day - birth_date.day;
        else
            s4_days_next = prev_len - borrow_day + now_date.day;
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_err_reg    <= s4_err_next;
            s4_years_reg  <= s4_years_next;
            s4_months_reg <= s4_months_next;
            s4_days_reg   <= s4_days_next;
        end
    end

    // Elapsed days, and day numbers divided by seven
    always_comb
    begin
        s5_total_next   = now_serial - birth_serial;
        prod_birth7     = 45'(birth_serial) * 45'(RECIP7);
        prod_now7       = 45'(now_serial) * 45'(RECIP7);
        s5_birth_q_next = prod_birth7[RECIP7_SHIFT +: WDAY_W];
        s5_now_q_next   = prod_now7[RECIP7_SHIFT +: WDAY_W];
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_err_reg      <= s4_err_reg;
            s5_years_reg    <= s4_years_reg;
            s5_months_reg   <= s4_months_reg;
            s5_days_reg     <= s4_days_reg;
            s5_total_reg    <= s5_total_next;
            s5_birth_lo_reg <= birth_serial[WDAY_W-1:0];
            s5_birth_q_reg  <= s5_birth_q_next;
            s5_now_lo_reg   <= now_serial[WDAY_W-1:0];
            s5_now_q_reg    <= s5_now_q_next;
        end
    end

    // Weeks, hours, and weekdays: s - 7q equals s + q in the low three bits
    always_comb
    begin
        prod_total7      = 45'(s5_total_reg) * 45'(RECIP7);
        s6_weeks_next    = prod_total7[RECIP7_SHIFT +: WEEKS_W];
        s6_hours_next    = (27'(s5_total_reg) << 4) + (27'(s5_total_reg) << 3);
        s6_birth_wd_next = s5_birth_lo_reg + s5_birth_q_reg;
        s6_now_wd_next   = s5_now_lo_reg + s5_now_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s6_err_reg      <= s5_err_reg;
            s6_years_reg    <= s5_years_reg;
            s6_months_reg   <= s5_months_reg;
            s6_days_reg     <= s5_days_reg;
            s6_total_reg    <= s5_total_reg;
            s6_weeks_reg    <= s6_weeks_next;
            s6_hours_reg    <= s6_hours_next;
            s6_birth_wd_reg <= s6_birth_wd_next;
            s6_now_wd_reg   <= s6_now_wd_next;
        end
    end

    // Minutes, and drop every field but date_error to zero on an error
    always_comb
    begin
        result_next = '0;
        if (s6_err_reg)
            result_next.date_error = 1'b1;
        else
        begin
            result_next.age_years     = s6_years_reg;
            result_next.age_months    = s6_months_reg;
            result_next.age_days      = s6_days_reg;
            result_next.total_days    = s6_total_reg;
            result_next.total_weeks   = s6_weeks_reg;
            result_next.total_hours   = s6_hours_reg;
            result_next.total_minutes = (33'(s6_hours_reg) << 6) - (33'(s6_hours_reg) << 2);
            result_next.birth_weekday = s6_birth_wd_reg;
            result_next.now_weekday   = s6_now_wd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[6])
            result_reg <= result_next;
    end

    // Checks
    `CAW_ASSERT(a_error_clears_fields, result_valid && result.date_error |-> result.total_days == '0 && result.age_years == '0 && result.now_weekday == '0 && result.birth_weekday == '0)
    `CAW_ASSERT(a_fields_in_range, result_valid && !result.date_error |-> result.age_months <= 4'd11 && result.age_days <= 5'd30 && result.birth_weekday <= 3'd6 && result.now_weekday <= 3'd6)
    `CAW_ASSERT(a_transfer_fills_first_stage, item_valid && !item_stall |=> vld_reg[0])
    `CAW_ASSERT_ALWAYS(a_stall_only_when_full, item_stall |-> vld_reg[0] && vld_reg[1])

endmodule
